// File: src/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: src/fsc_pkg.sv
// Shared types, widths and codes of the frustum sphere cull unit.
package fsc_pkg;

  localparam int REG_COUNT     = 6;
  localparam int PLANE_COUNT_D = 6;
  localparam int CFG_IDX_W     = $clog2(REG_COUNT);
  localparam int CFG_DATA_W    = 64;

  localparam int COORD_W  = 24;
  localparam int RADIUS_W = 24;
  localparam int NORM_W   = 12;
  localparam int OFFS_W   = 28;
  localparam int PROD_W   = NORM_W + COORD_W;
  localparam int DIST_W   = 40;
  localparam int SCALE_SH = 10;

  localparam logic [RADIUS_W-1:0] RADIUS_INF = '1;

  localparam logic [1:0] KIND_POINT  = 2'd0;
  localparam logic [1:0] KIND_FULL   = 2'd1;
  localparam logic [1:0] KIND_PART   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Register layout, lowest bits last: normal x at the bottom, offset on top.
  typedef struct packed {
    logic [OFFS_W-1:0] offset;
    logic [NORM_W-1:0] nz;
    logic [NORM_W-1:0] ny;
    logic [NORM_W-1:0] nx;
  } plane_t;

endpackage

// File: src/fsc_plane_regs.sv
// Clip plane register file written through the configuration channel.
module fsc_plane_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [fsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output fsc_pkg::plane_t                  planes [fsc_pkg::REG_COUNT]
);

  fsc_pkg::plane_t plane_q [fsc_pkg::REG_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fsc_pkg::REG_COUNT; i++) begin
        plane_q[i] <= '0;
      end
    end else if (cfg_valid && (cfg_index < fsc_pkg::CFG_IDX_W'(fsc_pkg::REG_COUNT))) begin
      // Indexes past the last plane register are dropped.
      plane_q[cfg_index] <= fsc_pkg::plane_t'(cfg_data);
    end
  end

  assign planes = plane_q;

endmodule

// File: src/fsc_plane_lane.sv
// One plane lane: products, two adder stages and the limit compare.
module fsc_plane_lane (
  input  logic                               clk,
  input  logic                               advance,
  input  fsc_pkg::plane_t                    plane,
  input  logic signed [fsc_pkg::COORD_W-1:0] point_x,
  input  logic signed [fsc_pkg::COORD_W-1:0] point_y,
  input  logic signed [fsc_pkg::COORD_W-1:0] point_z,
  input  logic signed [fsc_pkg::DIST_W-1:0]  limit,
  output logic                               pass
);

  logic signed [fsc_pkg::PROD_W-1:0] prod_x;
  logic signed [fsc_pkg::PROD_W-1:0] prod_y;
  logic signed [fsc_pkg::PROD_W-1:0] prod_z;
  logic signed [fsc_pkg::OFFS_W-1:0] offset_s1;
  logic signed [fsc_pkg::DIST_W-1:0] sum_xy;
  logic signed [fsc_pkg::DIST_W-1:0] sum_zo;
  logic signed [fsc_pkg::DIST_W-1:0] distance;
  logic signed [fsc_pkg::DIST_W-1:0] offset_scaled;

  // Offset moves from Q.8 to the Q.18 scale of the products.
  assign offset_scaled = fsc_pkg::DIST_W'($signed({offset_s1, {fsc_pkg::SCALE_SH{1'b0}}}));

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_x    <= $signed(plane.nx) * point_x;
      prod_y    <= $signed(plane.ny) * point_y;
      prod_z    <= $signed(plane.nz) * point_z;
      offset_s1 <= $signed(plane.offset);
      sum_xy    <= fsc_pkg::DIST_W'(prod_x) + fsc_pkg::DIST_W'(prod_y);
      sum_zo    <= fsc_pkg::DIST_W'(prod_z) + offset_scaled;
      distance  <= sum_xy + sum_zo;
      pass      <= !(distance < limit);
    end
  end

endmodule

// File: src/frustum_sphere_cull_unit.sv
// An input transfer moves through stage registers s1 to s4 and then into the output register.
// Throughput: one query per cycle unless the output holds; every plane has its own lane of multipliers and adders.
// The whole pipeline holds while a result waits and the output side is not ready.
// Reset clears the plane registers to zero and empties the pipeline.
// The configuration channel is always ready and takes a write in every cycle.
module frustum_sphere_cull_unit #(
  parameter int PLANE_COUNT = fsc_pkg::PLANE_COUNT_D
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // point_x [23:0], point_y [47:24], point_z [71:48], radius [95:72]
  input  logic [95:0]                      s_axis_tdata,
  // kind [1:0]
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // visible [0], zero fill [7:1]
  output logic [7:0]                       m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  fsc_pkg::plane_t planes [fsc_pkg::REG_COUNT];

  logic                                advance;
  logic signed [fsc_pkg::COORD_W-1:0]  in_x;
  logic signed [fsc_pkg::COORD_W-1:0]  in_y;
  logic signed [fsc_pkg::COORD_W-1:0]  in_z;
  logic [fsc_pkg::RADIUS_W-1:0]        in_r;
  logic [fsc_pkg::DIST_W-1:0]          r_scaled;
  logic signed [fsc_pkg::DIST_W-1:0]   limit_next;
  logic                                force_next;
  logic                                force_val_next;

  logic                                valid_s1, valid_s2, valid_s3, valid_s4;
  logic                                force_s1, force_s2, force_s3, force_s4;
  logic                                force_val_s1, force_val_s2, force_val_s3, force_val_s4;
  logic signed [fsc_pkg::DIST_W-1:0]   limit_s1, limit_s2, limit_s3;
  logic                                out_valid;
  logic                                out_visible;
  logic                                visible_next;
  logic [PLANE_COUNT-1:0]              lane_pass;

  fsc_plane_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .planes    (planes)
  );

  assign cfg_ready     = 1'b1;
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = advance;

  assign in_x     = s_axis_tdata[23:0];
  assign in_y     = s_axis_tdata[47:24];
  assign in_z     = s_axis_tdata[71:48];
  assign in_r     = s_axis_tdata[95:72];
  assign r_scaled = fsc_pkg::DIST_W'({in_r, {fsc_pkg::SCALE_SH{1'b0}}});

  // Infinite radius of a full or partial query and the unused kind settle the answer without the planes.
  always_comb begin
    limit_next     = '0;
    force_next     = 1'b0;
    force_val_next = 1'b0;
    case (s_axis_tuser)
      fsc_pkg::KIND_POINT: begin
        limit_next = '0;
      end
      fsc_pkg::KIND_FULL: begin
        limit_next = $signed(r_scaled);
        force_next = (in_r == fsc_pkg::RADIUS_INF);
      end
      fsc_pkg::KIND_PART: begin
        limit_next     = -$signed(r_scaled);
        force_next     = (in_r == fsc_pkg::RADIUS_INF);
        force_val_next = 1'b1;
      end
      default: begin
        force_next = 1'b1;
      end
    endcase
  end

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_lane
    fsc_pkg::plane_t lane_plane;
    if (i < fsc_pkg::REG_COUNT) begin : g_stored
      assign lane_plane = planes[i];
    end else begin : g_empty
      assign lane_plane = '0;
    end
    fsc_plane_lane u_lane (
      .clk     (clk),
      .advance (advance),
      .plane   (lane_plane),
      .point_x (in_x),
      .point_y (in_y),
      .point_z (in_z),
      .limit   (limit_s3),
      .pass    (lane_pass[i])
    );
  end

  assign visible_next = force_s4 ? force_val_s4 : (&lane_pass);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1  <= 1'b0;
      valid_s2  <= 1'b0;
      valid_s3  <= 1'b0;
      valid_s4  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      valid_s1  <= s_axis_tvalid;
      valid_s2  <= valid_s1;
      valid_s3  <= valid_s2;
      valid_s4  <= valid_s3;
      out_valid <= valid_s4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      force_s1     <= force_next;
      force_val_s1 <= force_val_next;
      limit_s1     <= limit_next;
      force_s2     <= force_s1;
      force_val_s2 <= force_val_s1;
      limit_s2     <= limit_s1;
      force_s3     <= force_s2;
      force_val_s3 <= force_val_s2;
      limit_s3     <= limit_s2;
      force_s4     <= force_s3;
      force_val_s4 <= force_val_s3;
      out_visible  <= visible_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_visible};

endmodule

// File: src/fsc_checker.sv
// Port-level checker of the frustum sphere cull unit and its bind.
`include "assert_macros.svh"

module fsc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [1:0]                       s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [7:0]                       m_axis_tdata
);

  // A result that waits keeps its value.
  `ASSERT_IMPLIES(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, ##1 (m_axis_tvalid && $stable(m_axis_tdata)))

  // The input side stalls while a result waits.
  `ASSERT_IMPLIES(a_stall_in, clk, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

  // An unused kind gives a blocked result when nothing stalls.
  `ASSERT_IMPLIES(a_unused_kind, clk, rst, s_axis_tvalid && s_axis_tready && (s_axis_tuser == fsc_pkg::KIND_UNUSED) ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready, ##1 (m_axis_tvalid && !m_axis_tdata[0]))

  // After reset no result is offered.
  `ASSERT_ALWAYS(a_reset_empty, clk, rst, ##1 !m_axis_tvalid)

endmodule

bind frustum_sphere_cull_unit fsc_checker u_checker (.*);
